@@ rtl/efp_pkg.sv @@
`default_nettype none
package efp_pkg;

    localparam int LANES    = 2;
    localparam int DW       = 64;
    localparam int LATENCY  = 10;

    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [62:0] INF_BITS    = 63'h7FF0_0000_0000_0000;
    localparam logic [10:0] EXP_MAX     = 11'h7FF;

    typedef struct packed {
        logic [DW-1:0] lane0_left;
        logic [DW-1:0] lane0_right;
        logic [DW-1:0] lane1_left;
        logic [DW-1:0] lane1_right;
    } t_in;

    typedef struct packed {
        logic [DW-1:0] lane0_product;
        logic [DW-1:0] lane0_error;
        logic [DW-1:0] lane1_product;
        logic [DW-1:0] lane1_error;
    } t_out;

    // leading zeros of a 53-bit significand
    function automatic logic [5:0] lzc53(input logic [52:0] v);
        logic [5:0] n;
        n = 6'd53;
        for (int i = 0; i < 53; i++) begin
            if (v[i]) begin
                n = 6'(52 - i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ rtl/efp_lane.sv @@
`default_nettype none
module efp_lane (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_left,
    input  wire logic [63:0] i_right,
    output logic [63:0]      o_product,
    output logic [63:0]      o_error
);
    import efp_pkg::*;

    // stage 1: decode, special operands, leading zeros
    logic [10:0] n_ea, n_eb;
    logic [51:0] n_fa, n_fb;
    logic        n_inf_a, n_inf_b, n_zero_a, n_zero_b, n_sign, n_spec;
    logic [63:0] n_pspec;

    always_comb begin
        n_ea     = i_left[62:52];
        n_eb     = i_right[62:52];
        n_fa     = i_left[51:0];
        n_fb     = i_right[51:0];
        n_sign   = i_left[63] ^ i_right[63];
        n_inf_a  = n_ea == EXP_MAX;
        n_inf_b  = n_eb == EXP_MAX;
        n_zero_a = n_ea == 11'd0 && n_fa == 52'd0;
        n_zero_b = n_eb == 11'd0 && n_fb == 52'd0;
        n_spec   = 1'b1;
        n_pspec  = '0;
        if (n_inf_a && n_fa != 52'd0) begin
            n_pspec = i_left | QUIET_BIT;
        end else if (n_inf_b && n_fb != 52'd0) begin
            n_pspec = i_right | QUIET_BIT;
        end else if ((n_inf_a && n_zero_b) || (n_zero_a && n_inf_b)) begin
            n_pspec = DEFAULT_NAN;
        end else if (n_inf_a || n_inf_b) begin
            n_pspec = {n_sign, INF_BITS};
        end else if (n_zero_a || n_zero_b) begin
            n_pspec = {n_sign, 63'd0};
        end else begin
            n_spec = 1'b0;
        end
    end

    logic [52:0] r1_ma, r1_mb;
    logic [5:0]  r1_lza, r1_lzb;
    logic [11:0] r1_esum;
    logic        r1_sign, r1_spec;
    logic [63:0] r1_pspec;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ma    <= {n_ea != 11'd0, n_fa};
            r1_mb    <= {n_eb != 11'd0, n_fb};
            r1_lza   <= lzc53({n_ea != 11'd0, n_fa});
            r1_lzb   <= lzc53({n_eb != 11'd0, n_fb});
            r1_esum  <= 12'(n_ea == 11'd0 ? 11'd1 : n_ea)
                      + 12'(n_eb == 11'd0 ? 11'd1 : n_eb);
            r1_sign  <= n_sign;
            r1_spec  <= n_spec;
            r1_pspec <= n_pspec;
        end
    end

    // stage 2: normalise both significands
    logic [52:0]        r2_ma, r2_mb;
    logic signed [13:0] r2_f;
    logic               r2_sign, r2_spec;
    logic [63:0]        r2_pspec;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ma    <= r1_ma << r1_lza;
            r2_mb    <= r1_mb << r1_lzb;
            r2_f     <= $signed(14'(r1_esum) - 14'd1022 - 14'(r1_lza) - 14'(r1_lzb));
            r2_sign  <= r1_sign;
            r2_spec  <= r1_spec;
            r2_pspec <= r1_pspec;
        end
    end

    // stage 3: four partial products
    logic [51:0]        r3_hh;
    logic [52:0]        r3_hl, r3_lh;
    logic [53:0]        r3_ll;
    logic signed [13:0] r3_f;
    logic               r3_sign, r3_spec;
    logic [63:0]        r3_pspec;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_hh    <= 52'(r2_ma[52:27]) * 52'(r2_mb[52:27]);
            r3_hl    <= 53'(r2_ma[52:27]) * 53'(r2_mb[26:0]);
            r3_lh    <= 53'(r2_ma[26:0]) * 53'(r2_mb[52:27]);
            r3_ll    <= 54'(r2_ma[26:0]) * 54'(r2_mb[26:0]);
            r3_f     <= r2_f;
            r3_sign  <= r2_sign;
            r3_spec  <= r2_spec;
            r3_pspec <= r2_pspec;
        end
    end

    // stage 4: full product, one-bit normalise, subnormal shift amount
    logic [105:0]       n_prod, n_x;
    logic signed [13:0] n_f, n_dt;
    logic [5:0]         n_d;

    always_comb begin
        n_prod = (106'(r3_hh) << 54) + ((106'(r3_hl) + 106'(r3_lh)) << 27) + 106'(r3_ll);
        n_x    = n_prod[105] ? n_prod : (n_prod << 1);
        n_f    = r3_f - (n_prod[105] ? 14'sd0 : 14'sd1);
        n_dt   = 14'sd1 - n_f;
        if (n_f >= 14'sd1) begin
            n_d = 6'd0;
        end else if (n_dt > 14'sd54) begin
            n_d = 6'd54;
        end else begin
            n_d = n_dt[5:0];
        end
    end

    logic [105:0]       r4_x;
    logic signed [13:0] r4_f;
    logic [5:0]         r4_d;
    logic               r4_sign, r4_spec;
    logic [63:0]        r4_pspec;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_x     <= n_x;
            r4_f     <= n_f;
            r4_d     <= n_d;
            r4_sign  <= r3_sign;
            r4_spec  <= r3_spec;
            r4_pspec <= r3_pspec;
        end
    end

    // stage 5: split kept bits from the remainder
    logic [6:0]   n_s;
    logic [106:0] n_xx, n_t;
    logic [107:0] n_mask;

    always_comb begin
        n_s    = 7'd53 + 7'(r4_d);
        n_xx   = {r4_x, 1'b0};
        n_t    = n_xx >> n_s;
        n_mask = (108'(1) << n_s) - 108'(1);
    end

    logic [52:0]        r5_kept, r5_rem;
    logic               r5_guard, r5_sticky, r5_rem_nz, r5_sub;
    logic [11:0]        r5_fb;
    logic signed [13:0] r5_f;
    logic               r5_sign, r5_spec;
    logic [63:0]        r5_pspec;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_kept   <= n_t[53:1];
            r5_guard  <= n_t[0];
            r5_sticky <= |(n_xx & n_mask[106:0]);
            r5_rem    <= r4_x[52:0] & n_mask[52:0];
            r5_rem_nz <= |(r4_x & n_mask[105:0]);
            r5_sub    <= r4_d != 6'd0;
            r5_fb     <= (r4_d == 6'd0) ? 12'(r4_f - 14'sd1) : 12'd0;
            r5_f      <= r4_f;
            r5_sign   <= r4_sign;
            r5_spec   <= r4_spec;
            r5_pspec  <= r4_pspec;
        end
    end

    // stage 6: round the product, form the exact residual
    logic        n_up, n_ovf;
    logic [53:0] n_r, n_res;
    logic [12:0] n_expf;
    logic [63:0] n_p;

    always_comb begin
        n_up   = r5_guard & (r5_sticky | r5_kept[0]);
        n_r    = 54'(r5_kept) + 54'(n_up);
        n_expf = 13'(r5_fb) + 13'(n_r[53:52]);
        n_ovf  = n_expf >= 13'(EXP_MAX);
        if (r5_spec) begin
            n_p = r5_pspec;
        end else if (n_ovf) begin
            n_p = {r5_sign, INF_BITS};
        end else begin
            n_p = {r5_sign, n_expf[10:0], n_r[51:0]};
        end
        n_res = n_up ? ((54'(1) << 53) - 54'(r5_rem)) : 54'(r5_rem);
    end

    logic [63:0]        r6_p;
    logic [52:0]        r6_res;
    logic               r6_rs, r6_errz, r6_sub;
    logic signed [13:0] r6_f2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_p    <= n_p;
            r6_res  <= n_res[52:0];
            r6_rs   <= r5_sign ^ n_up;
            r6_errz <= r5_spec | n_ovf | ~r5_rem_nz;
            r6_sub  <= r5_sub;
            r6_f2   <= r5_f - 14'sd53;
        end
    end

    // stage 7: leading zeros of the residual
    logic [63:0]        r7_p;
    logic [52:0]        r7_res;
    logic [5:0]         r7_lz;
    logic               r7_rs, r7_errz, r7_sub;
    logic signed [13:0] r7_f2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_p    <= r6_p;
            r7_res  <= r6_res;
            r7_lz   <= lzc53(r6_res);
            r7_rs   <= r6_rs;
            r7_errz <= r6_errz;
            r7_sub  <= r6_sub;
            r7_f2   <= r6_f2;
        end
    end

    // stage 8: normalise the residual, find its underflow shift
    logic signed [13:0] n_e2, n_dt2;
    logic [5:0]         n_d2;

    always_comb begin
        n_e2  = r7_f2 - 14'(r7_lz);
        n_dt2 = 14'sd1 - n_e2;
        if (n_e2 >= 14'sd1) begin
            n_d2 = 6'd0;
        end else if (n_dt2 > 14'sd54) begin
            n_d2 = 6'd54;
        end else begin
            n_d2 = n_dt2[5:0];
        end
    end

    logic [63:0] r8_p;
    logic [52:0] r8_m;
    logic [5:0]  r8_d2;
    logic [11:0] r8_fb2;
    logic        r8_rs, r8_errz, r8_sub;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_p    <= r7_p;
            r8_m    <= r7_res << r7_lz;
            r8_d2   <= n_d2;
            r8_fb2  <= (n_e2 >= 14'sd1) ? 12'(n_e2 - 14'sd1) : 12'd0;
            r8_rs   <= r7_rs;
            r8_errz <= r7_errz;
            r8_sub  <= r7_sub;
        end
    end

    // stage 9: shift the residual into the subnormal range
    logic [53:0] n_mm, n_t2;
    logic [54:0] n_mask2;

    always_comb begin
        n_mm    = {r8_m, 1'b0};
        n_t2    = n_mm >> r8_d2;
        n_mask2 = (55'(1) << r8_d2) - 55'(1);
    end

    logic [63:0] r9_p;
    logic [52:0] r9_kept;
    logic        r9_guard, r9_sticky;
    logic [11:0] r9_fb2;
    logic        r9_rs, r9_errz, r9_sub;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r9_p      <= r8_p;
            r9_kept   <= n_t2[53:1];
            r9_guard  <= n_t2[0];
            r9_sticky <= |(n_mm & n_mask2[53:0]);
            r9_fb2    <= r8_fb2;
            r9_rs     <= r8_rs;
            r9_errz   <= r8_errz;
            r9_sub    <= r8_sub;
        end
    end

    // stage 10: round and pack the error
    logic        n_up2;
    logic [53:0] n_r2;
    logic [12:0] n_expf2;
    logic [63:0] n_err;

    always_comb begin
        n_up2   = r9_guard & (r9_sticky | r9_kept[0]);
        n_r2    = 54'(r9_kept) + 54'(n_up2);
        n_expf2 = 13'(r9_fb2) + 13'(n_r2[53:52]);
        if (r9_errz) begin
            n_err = '0;
        end else if (r9_sub) begin
            n_err = {r9_rs, 63'd0};
        end else begin
            n_err = {r9_rs, n_expf2[10:0], n_r2[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_product <= r9_p;
            o_error   <= n_err;
        end
    end

endmodule
`default_nettype wire

@@ rtl/error_free_product.sv @@
// Ten register stages: the edge that accepts an input transaction loads the
// first stage, and the last stage is the output register that drives o_data.
// Throughput: one transaction per cycle unless a result is held at the output by a low i_ready; every lane in parallel.
// The rate is set by the ten-stage datapath per lane; the 53x53 significand
// product is cut into four partial products of 26- and 27-bit halves in stage 3.
// Reset (synchronous, active low) clears only the stage valid bits; the data
// registers are not reset and carry no meaning until their valid bit is set.
`default_nettype none
module error_free_product (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire efp_pkg::t_in   i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output efp_pkg::t_out       o_data
);
    import efp_pkg::*;

    // One valid bit per pipeline stage; the last one is the output register.
    logic [LATENCY-1:0] r_vld;
    logic               w_en;

    // Advance the whole pipeline unless a finished result is held at the
    // output; bubbles ride along, so nothing is lost or repeated on a stall.
    assign w_en    = ~r_vld[LATENCY-1] | i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_valid};
        end
    end

    // Unpack lanes into arrays so one generate loop can build them.
    logic [DW-1:0] w_left  [LANES];
    logic [DW-1:0] w_right [LANES];
    logic [DW-1:0] w_prod  [LANES];
    logic [DW-1:0] w_err   [LANES];

    assign w_left[0]  = i_data.lane0_left;
    assign w_right[0] = i_data.lane0_right;
    assign w_left[1]  = i_data.lane1_left;
    assign w_right[1] = i_data.lane1_right;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        efp_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_left    (w_left[g]),
            .i_right   (w_right[g]),
            .o_product (w_prod[g]),
            .o_error   (w_err[g])
        );
    end

    assign o_data.lane0_product = w_prod[0];
    assign o_data.lane0_error   = w_err[0];
    assign o_data.lane1_product = w_prod[1];
    assign o_data.lane1_error   = w_err[1];

    // A held result freezes every stage's valid bit.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    // A non-finite product carries a zero error.
    a_nonfinite_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.lane0_product[62:52] != EXP_MAX || o_data.lane0_error == '0)
                 && (o_data.lane1_product[62:52] != EXP_MAX || o_data.lane1_error == '0))
        else $error("error not zero for non-finite product");

    // The error never exceeds the product in magnitude.
    a_err_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.lane0_error[62:0] <= o_data.lane0_product[62:0])
                 && (o_data.lane1_error[62:0] <= o_data.lane1_product[62:0]))
        else $error("error larger than product");

endmodule
`default_nettype wire

@@ bench/efp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module efp_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_ready,
    input  wire efp_pkg::t_in   i_in_data,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_ready,
    input  wire efp_pkg::t_out  i_out_data,
    output int                  o_failures,
    output int                  o_pending
);
    import efp_pkg::*;

    localparam logic [63:0] HIDDEN = 64'h0010_0000_0000_0000;

    t_out products_due[$];

    function automatic int top_bit(input logic [127:0] x);
        int n;
        n = -1;
        for (int i = 0; i < 128; i++) begin
            if (x[i]) begin
                n = i;
            end
        end
        return n;
    endfunction

    // Round sign * x * 2^e to nearest-even binary64; hand back the exact remainder.
    function automatic logic [63:0] round_double(input bit sgn, input logic [127:0] x,
                                                 input int e, output logic [127:0] rem_out,
                                                 output bit rem_sgn);
        int q, sh, f;
        logic [127:0] kept, rem, half;
        logic [63:0] r;
        q = top_bit(x) + e - 52;
        if (q < -1074) q = -1074;
        sh = q - e;
        rem_out = '0;
        rem_sgn = sgn;
        if (sh <= 0) begin
            r = 64'(x << (-sh));
        end else if (sh > 120) begin
            r = '0;
            rem_out = x;
        end else begin
            kept = x >> sh;
            rem = x - (kept << sh);
            half = 128'b1 << (sh - 1);
            r = kept[63:0];
            if (rem > half || (rem == half && r[0])) begin
                r++;
                rem_out = (128'b1 << sh) - rem;
                rem_sgn = !sgn;
            end else begin
                rem_out = rem;
            end
        end
        if (r == (HIDDEN << 1)) begin
            r = r >> 1;
            q++;
        end
        if (r >= HIDDEN) begin
            f = q + 1075;
            if (f >= 2047) return {sgn, INF_BITS};
            return {sgn, 11'(f), r[51:0]};
        end
        return {sgn, 11'b0, r[51:0]};
    endfunction

    function automatic void two_product(input logic [63:0] a, input logic [63:0] b,
                                        output logic [63:0] p, output logic [63:0] err);
        logic [10:0] ea, eb;
        logic [51:0] fa, fb;
        logic [127:0] ma, mb, res, spare;
        bit s, rs, ss, inf_a, inf_b, zero_a, zero_b;
        int xe;
        ea = a[62:52];
        eb = b[62:52];
        fa = a[51:0];
        fb = b[51:0];
        s = a[63] ^ b[63];
        inf_a = ea == EXP_MAX;
        inf_b = eb == EXP_MAX;
        zero_a = ea == 0 && fa == 0;
        zero_b = eb == 0 && fb == 0;
        err = '0;
        if (inf_a && fa != 0) begin
            p = a | QUIET_BIT;
        end else if (inf_b && fb != 0) begin
            p = b | QUIET_BIT;
        end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
            p = DEFAULT_NAN;
        end else if (inf_a || inf_b) begin
            p = {s, INF_BITS};
        end else if (zero_a || zero_b) begin
            p = {s, 63'b0};
        end else begin
            ma = {75'b0, ea != 0, fa};
            mb = {75'b0, eb != 0, fb};
            xe = (ea != 0 ? int'(ea) : 1) + (eb != 0 ? int'(eb) : 1) - 2150;
            p = round_double(s, ma * mb, xe, res, rs);
            if (p[62:52] != EXP_MAX && res != 0) begin
                err = round_double(rs, res, xe, spare, ss);
            end
        end
    endfunction

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            o_failures++;
        end
    endtask

    assign o_pending = products_due.size();

    initial o_failures = 0;

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            two_product(i_in_data.lane0_left, i_in_data.lane0_right,
                        want.lane0_product, want.lane0_error);
            two_product(i_in_data.lane1_left, i_in_data.lane1_right,
                        want.lane1_product, want.lane1_error);
            products_due.push_back(want);
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (products_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, i_out_data);
                o_failures++;
            end else begin
                want = products_due.pop_front();
                check_field("lane0_product", want.lane0_product, i_out_data.lane0_product);
                check_field("lane0_error", want.lane0_error, i_out_data.lane0_error);
                check_field("lane1_product", want.lane1_product, i_out_data.lane1_product);
                check_field("lane1_error", want.lane1_error, i_out_data.lane1_error);
            end
        end
    end
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import efp_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 400000;
    // receiver hold-off window, in cycles after reset release
    localparam int HOLD_START   = 1500;
    localparam int HOLD_CYCLES  = 300;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_ready = 1'b0;
    t_in   i_data = '0;
    logic  o_ready;
    logic  o_valid;
    t_out  o_data;
    int    failures;
    int    pending;
    int    cycles = 0;

    always #4 i_clk = ~i_clk;

    error_free_product uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    efp_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_data  (o_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("error_free_product test failed");
            $finish;
        end
    end

    // Receiver: stall on its own pattern; hold off for a long stretch once
    // so that the pipeline fills and back-pressures the sender.
    always @(posedge i_clk) begin
        int run_cycles;
        int mode;
        if (!i_rst_n) begin
            run_cycles = 0;
            i_ready <= 1'b0;
        end else begin
            run_cycles++;
            if (run_cycles % 400 == 0) mode = $urandom_range(0, 3);
            if (run_cycles >= HOLD_START && run_cycles < HOLD_START + HOLD_CYCLES) begin
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= ($urandom_range(0, 1) != 0);
                    default: i_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Hold the transaction until the block takes it; ready is stable by the falling edge
    task automatic offer(input t_in item);
        i_valid <= 1'b1;
        i_data <= item;
        @(negedge i_clk);
        while (!o_ready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic idle_for(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Wait for the count of outstanding results to settle at the falling edge
    task automatic drain;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Mix of plain, mid-range, huge, tiny, subnormal and special operands
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            3, 4, 5: v[62:52] = 11'(990 + $urandom_range(0, 66));
            6: v[62:52] = 11'(1900 + $urandom_range(0, 146));
            7: v[62:52] = 11'($urandom_range(0, 120));
            8: v[62:52] = 11'b0;
            9: begin
                case ($urandom_range(0, 5))
                    0: v[62:0] = '0;
                    1: v[62:0] = INF_BITS;
                    2: v[62:0] = {EXP_MAX, 1'b1, v[50:0]};
                    3: v[62:0] = {EXP_MAX, 1'b0, v[50:1], 1'b1};
                    4: v[62:0] = 63'h7FEF_FFFF_FFFF_FFFF;
                    default: v[62:0] = 63'h1;
                endcase
            end
            default: ;
        endcase
        // trim low bits now and then so that exact products appear
        if ($urandom_range(0, 7) == 0) v[30:0] = '0;
        return v;
    endfunction

    // Directed operand pairs: special cases, extremes and signs
    logic [63:0] pairs [0:19][0:1] = '{
        '{64'h7FF4_0000_0000_0001, 64'h3FF0_0000_0000_0000},  // signalling NaN left
        '{64'h3FF0_0000_0000_0000, 64'hFFF8_0000_0000_0123},  // NaN right
        '{64'h7FF0_0000_0000_0005, 64'hFFF8_0000_0000_0077},  // both NaN, left wins
        '{64'h7FF0_0000_0000_0000, 64'h0000_0000_0000_0000},  // infinity times zero
        '{64'h8000_0000_0000_0000, 64'hFFF0_0000_0000_0000},  // zero times infinity
        '{64'hFFF0_0000_0000_0000, 64'h4000_0000_0000_0000},  // infinity times finite
        '{64'h8000_0000_0000_0000, 64'h4008_0000_0000_0000},  // signed zero
        '{64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF},  // overflow
        '{64'h7FE0_0000_0000_0000, 64'hC000_0000_0000_0000},  // overflow, negative
        '{64'h4000_0000_0000_0000, 64'h4008_0000_0000_0000},  // exact product
        '{64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0001},  // nonzero residual
        '{64'hBFF0_0000_0000_0001, 64'h3FFF_FFFF_FFFF_FFFF},  // residual, negative
        '{64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001},  // underflow to zero
        '{64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF},  // subnormal times huge
        '{64'h000F_FFFF_FFFF_FFFF, 64'h3FF8_0000_0000_0001},  // subnormal operand, normal result
        '{64'h2000_0000_0000_0001, 64'h2000_0000_0000_0003},  // residual underflows
        '{64'h0010_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF},  // rounds up to normal
        '{64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000},  // largest finite
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000},  // all ones NaN
        '{64'h3FF5_5555_5555_5555, 64'h4008_0000_0000_0000}   // rounding tie, to even
    };

    initial begin
        t_in item;
        int burst;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: lane 1 gets the pair swapped to cover operand order
        for (int i = 0; i < 20; i++) begin
            item.lane0_left = pairs[i][0];
            item.lane0_right = pairs[i][1];
            item.lane1_left = pairs[i][1];
            item.lane1_right = pairs[i][0];
            offer(item);
        end
        drain();

        // random part in bursts with gaps between some of them
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
                item.lane0_left = pick_operand();
                item.lane0_right = pick_operand();
                item.lane1_left = pick_operand();
                item.lane1_right = pick_operand();
                offer(item);
            end
            if (n == RANDOM_ITEMS / 2) drain();
            else if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 12));
        end
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        if (failures == 0) begin
            $display("error_free_product test passed");
        end else begin
            $display("error_free_product test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/efp_pkg.sv
rtl/efp_lane.sv
rtl/error_free_product.sv
bench/efp_checker.sv
bench/tb.sv
